// ===== hw/rtl/acl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 1;

    // rights mask bit positions
    localparam int RT_EXEC   = 0;
    localparam int RT_WRITE  = 1;
    localparam int RT_READ   = 2;
    localparam int RT_APPEND = 3;
    localparam int RT_DELETE = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUBJECT_FLAGS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBJECT_LEVEL = 1'b1;

    typedef enum logic [2:0] {
        RSN_NONE   = 3'd0,
        RSN_LEVEL  = 3'd1,
        RSN_EXEC   = 3'd2,
        RSN_WRITE  = 3'd3,
        RSN_READ   = 3'd4,
        RSN_APPEND = 3'd5,
        RSN_UNLINK = 3'd6,
        RSN_DELETE = 3'd7
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_DECIDE
    } state_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic              deny;
        logic [DATA_W-1:0] etype;
        logic [DATA_W-1:0] rights;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acl_access_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                              | Transfer
// ----------+------------------------------------------------------+-----------------------
// command   | start, op, entry_*, object_*, access_mask, extra_mask | start && !busy
// result    | done, granted, deny_reason, effective_rights          | done (one cycle)
// config    | cfg_we, cfg_index, cfg_data                           | cfg_we
//
// A table write takes effect at the command transfer; its result shows in the next cycle.
// A check denied by the level rule also answers in the cycle after transfer.
// Any other check walks the table memory one entry a cycle, then passes ST_FLUSH and
// ST_DECIDE before its result; the walk pace is set by the single memory read port.
// busy is high while a check walks, flushes or decides; the result side cannot stall,
// and a new command may transfer in the same cycle as a result strobe.
// Reset clears the valid marks, the configuration registers and the control state;
// entry contents stay undefined until written.

module acl_access_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [3:0]                    entry_index,
    input  wire logic                          entry_valid,
    input  wire logic                          entry_is_deny,
    input  wire logic [31:0]                   entry_type,
    input  wire logic [31:0]                   entry_rights,
    input  wire logic [31:0]                   object_type,
    input  wire logic [31:0]                   object_level,
    input  wire logic [3:0]                    access_mask,
    input  wire logic [1:0]                    extra_mask,
    // result
    output logic                               done,
    output logic                               granted,
    output logic [2:0]                         deny_reason,
    output logic [31:0]                        effective_rights,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [acl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam logic [acl_pkg::IDX_W-1:0] LAST_IDX =
        acl_pkg::IDX_W'(acl_pkg::TABLE_ENTRIES - 1);

    // configuration registers
    logic [1:0]  flags_reg;
    logic [31:0] level_reg;

    // table: valid marks in flops, the rest in a synchronous memory
    logic                   valid_reg [acl_pkg::TABLE_ENTRIES];
    acl_pkg::entry_t        mem [acl_pkg::TABLE_ENTRIES];
    acl_pkg::entry_t        rd_data_reg;
    logic                   rd_vld_reg;
    logic                   rd_val_reg;

    acl_pkg::state_t        state_reg, state_next;
    logic [acl_pkg::IDX_W-1:0] cnt_reg, cnt_next;

    // captured check request
    logic [31:0] otype_reg;
    logic [3:0]  amask_reg;
    logic [1:0]  xmask_reg;
    logic [31:0] allow_reg, allow_next;
    logic [31:0] deny_reg, deny_next;

    // result registers
    logic        done_reg, done_next;
    logic        granted_reg, granted_next;
    logic [2:0]  reason_reg, reason_next;
    logic [31:0] rights_reg, rights_next;

    logic                      accept;
    logic                      wr_en;
    logic                      in_range;
    logic                      lvl_deny;
    logic [acl_pkg::IDX_W-1:0] wr_addr;
    logic [31:0]               perm;
    acl_pkg::reason_t          reason;

    assign busy     = (state_reg != acl_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({3'b000, entry_index} < 7'(acl_pkg::TABLE_ENTRIES));
    assign wr_en    = accept && op && in_range;
    assign wr_addr  = acl_pkg::IDX_W'(entry_index);
    assign lvl_deny = flags_reg[1] && (object_level > level_reg);

    assign done             = done_reg;
    assign granted          = granted_reg;
    assign deny_reason      = reason_reg;
    assign effective_rights = rights_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 2'b00;
            level_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                acl_pkg::CFG_SUBJECT_FLAGS: flags_reg <= cfg_data[1:0];
                acl_pkg::CFG_SUBJECT_LEVEL: level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < acl_pkg::TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= entry_valid;
        end
    end

    // entry memory: one write port at transfer, one registered read port for the walk
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{deny: entry_is_deny, etype: entry_type, rights: entry_rights};
        end
        rd_data_reg <= mem[cnt_reg];
    end

    // read tag: marks a walk read and carries that entry's valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_val_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == acl_pkg::ST_WALK);
            rd_val_reg <= valid_reg[cnt_reg];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            otype_reg <= object_type;
            amask_reg <= access_mask;
            xmask_reg <= extra_mask;
        end
    end

    // final rights and first failing test
    assign perm = allow_reg & ~deny_reg;

    always_comb
    begin
        if (amask_reg[0] && !perm[acl_pkg::RT_EXEC])
            reason = acl_pkg::RSN_EXEC;
        else if (amask_reg[1] && !perm[acl_pkg::RT_WRITE])
            reason = acl_pkg::RSN_WRITE;
        else if (amask_reg[2] && !perm[acl_pkg::RT_READ])
            reason = acl_pkg::RSN_READ;
        else if (amask_reg[3] && !perm[acl_pkg::RT_APPEND] && !perm[acl_pkg::RT_WRITE])
            reason = acl_pkg::RSN_APPEND;
        else if (xmask_reg[1] && !perm[acl_pkg::RT_WRITE])
            reason = acl_pkg::RSN_UNLINK;
        else if (xmask_reg[0] && !perm[acl_pkg::RT_DELETE])
            reason = acl_pkg::RSN_DELETE;
        else
            reason = acl_pkg::RSN_NONE;
    end

    // state, counter, accumulators and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acl_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        allow_reg   <= allow_next;
        deny_reg    <= deny_next;
        granted_reg <= granted_next;
        reason_reg  <= reason_next;
        rights_reg  <= rights_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        allow_next   = allow_reg;
        deny_next    = deny_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        reason_next  = reason_reg;
        rights_next  = rights_reg;

        // fold in the entry read last cycle
        if (rd_vld_reg && rd_val_reg && (rd_data_reg.etype == otype_reg))
        begin
            if (rd_data_reg.deny)
                deny_next = deny_reg | rd_data_reg.rights;
            else
                allow_next = allow_reg | rd_data_reg.rights;
        end

        case (state_reg)
            acl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op)
                    begin
                        done_next    = 1'b1;
                        granted_next = in_range;
                        reason_next  = acl_pkg::RSN_NONE;
                        rights_next  = 32'd0;
                    end
                    else if (lvl_deny)
                    begin
                        done_next    = 1'b1;
                        granted_next = 1'b0;
                        reason_next  = acl_pkg::RSN_LEVEL;
                        rights_next  = 32'd0;
                    end
                    else
                    begin
                        // type enforcement starts from default deny if flags bit 0 is set, else from all allowed
                        allow_next = flags_reg[0] ? 32'd0 : '1;
                        deny_next  = 32'd0;
                        cnt_next   = '0;
                        state_next = acl_pkg::ST_WALK;
                    end
                end
            end
            acl_pkg::ST_WALK:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = acl_pkg::ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            acl_pkg::ST_FLUSH:
            begin
                state_next = acl_pkg::ST_DECIDE;
            end
            acl_pkg::ST_DECIDE:
            begin
                done_next    = 1'b1;
                granted_next = (reason == acl_pkg::RSN_NONE);
                reason_next  = reason;
                rights_next  = perm;
                state_next   = acl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = acl_pkg::ST_IDLE;
            end
        endcase
    end

    // a result follows only a decision, a table write or a level denial
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == acl_pkg::ST_DECIDE
                       || (accept && (op || lvl_deny))))
        else $error("result strobe without a source");

    // the table is never written while a walk reads it
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acl_pkg::ST_WALK) |-> !wr_en)
        else $error("table write during walk");

    // walk visits entries in order
    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acl_pkg::ST_WALK && cnt_reg != LAST_IDX)
        |=> (state_reg == acl_pkg::ST_WALK && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("walk counter skipped");

    // a granted result carries no denial reason
    a_grant_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> (deny_reason == acl_pkg::RSN_NONE))
        else $error("granted with a reason");

    // level denial reports no rights
    a_level_rights: assert property (@(posedge clk) disable iff (!rst_n)
        (done && deny_reason == acl_pkg::RSN_LEVEL) |-> (effective_rights == 32'd0 && !granted))
        else $error("level denial with rights");

endmodule

`default_nettype wire
